[rtl/ptt_pkg.sv]
// Package for the periodic timer table: command and status codes, types.
package ptt_pkg;

    localparam int DefaultEntries = 16;
    localparam int KeyW    = 24;
    localparam int PeriodW = 32;
    localparam int CountW  = 64;
    localparam int MaxEvents = 16;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_DESTROY = 3'd2,
        CMD_START   = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_RESUME  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_BADPERIOD = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_ENABLE        = 1'b0,
        REG_REPORT_ENABLE = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_TICK_RD,
        S_TICK_MOD,
        S_TICK_WAIT,
        S_TICK_CHK,
        S_START_MOD,
        S_START_WAIT,
        S_RESULT,
        S_OUT
    } state_t;

    // request to / answer from the shared modulo unit
    typedef struct packed {
        logic                start;
        logic [CountW-1:0]   dividend;
        logic [PeriodW-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PeriodW-1:0]  remainder;
    } mod_rsp_t;

endpackage

[rtl/periodic_timer_table_top.sv]
// Top level of the periodic timer table: sequencer, entry store, output register.
//
//  channel  | dir | handshake        | payload
//  s_axis   | in  | tvalid/tready    | tdata: command, owner_handle, timer_label,
//           |     |                  |        period_ticks, repeat_mode
//  m_axis   | out | tvalid/tready    | tdata: event_handle, event_label, status;
//           |     |                  | tuser: fired; tlast: last
//  cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// Commands other than tick raise the result after slot scan, decide and result; a
// start with a zero period skips the scan, and a start that finds its entry also
// takes the serial 64-by-32 remainder of the tick count.
// A tick, when enabled and with any slot valid, walks every slot (fetch, launch,
// remainder on the single shared unit, check); a stalled output holds the walk.
// Input is not ready until the last result is taken.
// Reset clears flags, tick count and config registers; no memory clearing pass.
module periodic_timer_table_top
    import ptt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DefaultEntries
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] command, [18:3] owner_handle, [26:19] timer_label,
    // [58:27] period_ticks, [59] repeat_mode, [63:60] zero
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] event_handle, [23:16] event_label, [26:24] status, [31:27] zero
    output logic [31:0] m_axis_tdata,
    // [0] fired
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);
    localparam int EvW  = $clog2(MaxEvents + 1);

    // entry store
    logic [KeyW-1:0]    key_mem    [TABLE_ENTRIES];
    logic [PeriodW-1:0] period_mem [TABLE_ENTRIES];
    logic [PeriodW-1:0] phase_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, run_reg, rpt_reg;

    logic enable_reg, report_reg;
    logic [CountW-1:0] tick_reg;

    state_t state_reg, state_next;

    // latched command
    logic [2:0]         cmd_reg;
    logic [KeyW-1:0]    key_reg;
    logic [PeriodW-1:0] per_reg;
    logic               rep_reg;

    // scan results
    logic [CntW-1:0] idx_reg;
    logic            hit_reg, free_reg;
    logic [IdxW-1:0] hit_idx_reg, free_idx_reg;
    logic [2:0]      status_reg;
    logic [EvW-1:0]  ev_cnt_reg;

    // fetched entry for tick walk
    logic [KeyW-1:0]    e_key_reg;
    logic [PeriodW-1:0] e_per_reg;
    logic [PeriodW-1:0] e_ph_reg;

    // pending event, reported once a later one or the end is known
    logic            pend_reg;
    logic [KeyW-1:0] pend_key_reg;

    // output register
    logic        ovalid_reg;
    logic [31:0] odata_reg;
    logic        ouser_reg, olast_reg;

    mod_req_t mreq;
    mod_rsp_t mrsp;

    ptt_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    logic [IdxW-1:0] cur;
    logic            last_slot;
    logic            scan_cmd;
    logic            fires;
    logic            out_free;

    assign cur       = idx_reg[IdxW-1:0];
    assign last_slot = (idx_reg == CntW'(TABLE_ENTRIES - 1));
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign scan_cmd  = (cmd_reg == CMD_CREATE) || (cmd_reg == CMD_DESTROY) ||
                       (cmd_reg == CMD_START) || (cmd_reg == CMD_STOP) ||
                       (cmd_reg == CMD_RESUME);
    assign fires     = valid_reg[cur] && run_reg[cur] && (e_per_reg != '0) &&
                       (mrsp.remainder == e_ph_reg);

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tdata[2:0] == CMD_TICK)
                        state_next = (enable_reg && (|valid_reg)) ? S_TICK_RD : S_IDLE;
                    else if (s_axis_tdata[2:0] == CMD_START && s_axis_tdata[58:27] == '0)
                        state_next = S_RESULT;
                    else
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (last_slot)
                    state_next = S_DECIDE;
            S_DECIDE:
                state_next = (cmd_reg == CMD_START && hit_reg) ? S_START_MOD : S_RESULT;
            S_START_MOD:
                state_next = S_START_WAIT;
            S_START_WAIT:
                if (mrsp.done)
                    state_next = S_RESULT;
            S_RESULT:
                if (out_free)
                    state_next = S_IDLE;
            S_TICK_RD:
                state_next = S_TICK_MOD;
            S_TICK_MOD:
                state_next = S_TICK_WAIT;
            S_TICK_WAIT:
                if (mrsp.done)
                    state_next = S_TICK_CHK;
            S_TICK_CHK:
                if (out_free)
                    state_next = last_slot ? S_OUT : S_TICK_RD;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // modulo requests
    always_comb
    begin
        mreq.start    = (state_reg == S_START_MOD) || (state_reg == S_TICK_MOD);
        mreq.dividend = tick_reg;
        mreq.divisor  = (state_reg == S_START_MOD) ? per_reg : e_per_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            report_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:        enable_reg <= cfg_data;
                REG_REPORT_ENABLE: report_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            run_reg    <= '0;
            rpt_reg    <= '0;
            tick_reg   <= '0;
            idx_reg    <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            ev_cnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg    <= '0;
                    hit_reg    <= 1'b0;
                    free_reg   <= 1'b0;
                    pend_reg   <= 1'b0;
                    ev_cnt_reg <= '0;
                    if (s_axis_tvalid && s_axis_tready &&
                        s_axis_tdata[2:0] == CMD_TICK && enable_reg && (|valid_reg))
                        tick_reg <= tick_reg + 1'b1;
                end
                S_SCAN:
                begin
                    if (valid_reg[cur] && key_mem[cur] == key_reg && !hit_reg)
                        hit_reg <= 1'b1;
                    if (!valid_reg[cur] && !free_reg)
                        free_reg <= 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
                S_DECIDE:
                begin
                    if (cmd_reg == CMD_CREATE && !hit_reg && free_reg)
                        valid_reg[free_idx_reg] <= 1'b1;
                    if (cmd_reg == CMD_CREATE && !hit_reg && free_reg)
                        run_reg[free_idx_reg] <= 1'b0;
                    if (hit_reg)
                    begin
                        case (cmd_reg)
                            CMD_DESTROY:
                            begin
                                valid_reg[hit_idx_reg] <= 1'b0;
                                run_reg[hit_idx_reg]   <= 1'b0;
                                rpt_reg[hit_idx_reg]   <= 1'b0;
                            end
                            CMD_START:
                            begin
                                run_reg[hit_idx_reg] <= 1'b1;
                                rpt_reg[hit_idx_reg] <= rep_reg;
                            end
                            CMD_STOP:   run_reg[hit_idx_reg] <= 1'b0;
                            CMD_RESUME: run_reg[hit_idx_reg] <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_RESULT:
                    if (out_free)
                        ovalid_reg <= 1'b1;
                S_TICK_CHK:
                    if (out_free)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (fires)
                        begin
                            if (!rpt_reg[cur])
                                run_reg[cur] <= 1'b0;
                            if (report_reg && ev_cnt_reg != EvW'(MaxEvents))
                            begin
                                ev_cnt_reg <= ev_cnt_reg + 1'b1;
                                pend_reg   <= 1'b1;
                                if (pend_reg)
                                    ovalid_reg <= 1'b1;
                            end
                        end
                    end
                S_OUT:
                    if (out_free)
                    begin
                        if (pend_reg)
                            ovalid_reg <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // payload and store
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd_reg    <= s_axis_tdata[2:0];
                    key_reg    <= {s_axis_tdata[18:3], s_axis_tdata[26:19]};
                    per_reg    <= s_axis_tdata[58:27];
                    rep_reg    <= s_axis_tdata[59];
                    status_reg <= (s_axis_tdata[2:0] == CMD_START &&
                                   s_axis_tdata[58:27] == '0) ? ST_BADPERIOD : ST_OK;
                end
            S_SCAN:
            begin
                if (valid_reg[cur] && key_mem[cur] == key_reg && !hit_reg)
                    hit_idx_reg <= cur;
                if (!valid_reg[cur] && !free_reg)
                    free_idx_reg <= cur;
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_CREATE)
                begin
                    if (hit_reg)
                        status_reg <= ST_DUP;
                    else if (!free_reg)
                        status_reg <= ST_FULL;
                    else
                        key_mem[free_idx_reg] <= key_reg;
                end
                else if (scan_cmd && !hit_reg)
                    status_reg <= ST_NOTFOUND;
                if (cmd_reg == CMD_START && hit_reg)
                    period_mem[hit_idx_reg] <= per_reg;
            end
            S_START_WAIT:
                if (mrsp.done)
                    phase_mem[hit_idx_reg] <= mrsp.remainder;
            S_RESULT:
                if (out_free)
                begin
                    odata_reg <= {5'd0, status_reg, 24'd0};
                    ouser_reg <= 1'b0;
                    olast_reg <= 1'b1;
                end
            S_TICK_RD:
            begin
                e_key_reg <= key_mem[cur];
                e_per_reg <= valid_reg[cur] ? period_mem[cur] : '0;
                e_ph_reg  <= phase_mem[cur];
            end
            S_TICK_CHK:
                if (out_free && fires && report_reg && ev_cnt_reg != EvW'(MaxEvents))
                begin
                    pend_key_reg <= e_key_reg;
                    odata_reg    <= {5'd0, ST_OK, pend_key_reg[7:0], pend_key_reg[23:8]};
                    ouser_reg    <= 1'b1;
                    olast_reg    <= 1'b0;
                end
            S_OUT:
                if (out_free)
                begin
                    odata_reg <= {5'd0, ST_OK, pend_key_reg[7:0], pend_key_reg[23:8]};
                    ouser_reg <= 1'b1;
                    olast_reg <= 1'b1;
                end
            default: ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    // no input taken while a result still waits
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !s_axis_tready)
        else $error("input ready with pending output");
    // command result always closes its group
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !ouser_reg |-> olast_reg)
        else $error("command result without last");
    // event count never exceeds the report limit
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_cnt_reg <= EvW'(MaxEvents))
        else $error("event count overflow");
    // remainder unit only busy in wait states
    assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.busy |-> (state_reg == S_TICK_WAIT || state_reg == S_START_WAIT))
        else $error("modulo unit busy out of sequence");

endmodule

[rtl/ptt_mod.sv]
// Bit-serial 64-by-32 remainder unit, one dividend bit per cycle.
module ptt_mod
    import ptt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int CntW = $clog2(CountW + 1);

    logic [CountW-1:0]  dvd_reg;
    logic [PeriodW-1:0] dvs_reg;
    logic [PeriodW:0]   rem_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [PeriodW+1:0] shifted;
    logic [PeriodW+1:0] diff;

    // shift in next dividend bit, conditional subtract
    assign shifted = {rem_reg, dvd_reg[CountW-1]};
    assign diff    = shifted - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(CountW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CountW-2:0], 1'b0};
            if (!diff[PeriodW+1])
                rem_reg <= diff[PeriodW:0];
            else
                rem_reg <= shifted[PeriodW:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[PeriodW-1:0];

    // a finished remainder is below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && dvs_reg != '0 |-> rem_reg < {1'b0, dvs_reg})
        else $error("remainder not reduced");
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("start did not launch");

endmodule
